/* src/ps2_mouse_packet_cursor_tracker_macros.svh */
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker assertion macros
// Concurrent check wrappers, sampled on clk with reset masked.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define PMCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true outside reset
`define PMCT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PMCT_ASSERT(label, prop, msg)
`define PMCT_NEVER(label, expr, msg)
`endif
`endif

/* src/pmct_pkg.sv */
// ----------------------------------------------------------------------------
// pmct_pkg
// Shared widths, register map, packet phase codes and status bit positions.
// ----------------------------------------------------------------------------
package pmct_pkg;

    // field and bus widths
    localparam int SIZE_W  = 13;
    localparam int DELTA_W = 9;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // parameter defaults
    localparam int DEFAULT_MARGIN     = 12;
    localparam int DEFAULT_COORD_BITS = 12;

    // register reset values
    localparam logic [SIZE_W-1:0] RST_WIDTH  = 13'd1024;
    localparam logic [SIZE_W-1:0] RST_HEIGHT = 13'd768;

    // register index (paddr bit 2)
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // packet phase codes
    localparam logic [1:0] PH_STATUS = 2'd0;
    localparam logic [1:0] PH_X      = 2'd1;
    localparam logic [1:0] PH_Y      = 2'd2;

    // status byte bits
    localparam int ST_LEFT   = 0;
    localparam int ST_RIGHT  = 1;
    localparam int ST_MIDDLE = 2;
    localparam int ST_ONE    = 3;
    localparam int ST_XSIGN  = 4;
    localparam int ST_YSIGN  = 5;
    localparam int ST_XOVF   = 6;
    localparam int ST_YOVF   = 7;

    typedef logic signed [DELTA_W-1:0] delta_t;

    // elaboration-time clamp limit, used for reset positions
    function automatic int axis_lim_const(int size, int margin, int coord_bits);
        int lim;
        lim = size - margin;
        if (lim < 0)
            lim = 0;
        if (lim > (1 << coord_bits) - 1)
            lim = (1 << coord_bits) - 1;
        return lim;
    endfunction

endpackage

/* src/pmct_axis.sv */
// ----------------------------------------------------------------------------
// pmct_axis
// One cursor axis: step or recenter, clamp to 0..size-margin within COORD_BITS.
// ----------------------------------------------------------------------------
module pmct_axis #(
    parameter int CURSOR_MARGIN = pmct_pkg::DEFAULT_MARGIN,
    parameter int COORD_BITS    = pmct_pkg::DEFAULT_COORD_BITS
) (
    input  logic [pmct_pkg::SIZE_W-1:0]        size,
    input  logic [COORD_BITS-1:0]              pos,
    input  logic signed [pmct_pkg::DELTA_W:0]  step,
    input  logic                               center,
    output logic [COORD_BITS-1:0]              pos_next
);

    localparam int CW = ((COORD_BITS > pmct_pkg::SIZE_W) ? COORD_BITS : pmct_pkg::SIZE_W) + 2;
    localparam logic signed [CW-1:0] MARGIN_S    = CW'(CURSOR_MARGIN);
    localparam logic signed [CW-1:0] COORD_MAX_S = CW'((1 << COORD_BITS) - 1);

    logic signed [CW-1:0] span;
    logic signed [CW-1:0] lim;
    logic signed [CW-1:0] target;
    logic signed [CW-1:0] clamped;

    // limit, then target, then clamp
    always_comb
    begin
        span = signed'(CW'(size)) - MARGIN_S;
        if (span < 0)
            lim = '0;
        else if (span > COORD_MAX_S)
            lim = COORD_MAX_S;
        else
            lim = span;

        if (center)
            target = signed'(CW'(size >> 1));
        else
            target = signed'(CW'(pos)) + CW'(step);

        if (target < 0)
            clamped = '0;
        else if (target > lim)
            clamped = lim;
        else
            clamped = target;

        pos_next = clamped[COORD_BITS-1:0];
    end

endmodule

/* src/ps2_mouse_packet_cursor_tracker.sv */
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker
// Frames PS/2 mouse bytes into three-byte packets and tracks a clamped cursor.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one received byte per transfer
// with from_mouse and recenter flags. Bytes with from_mouse low are taken and
// dropped; recenter moves the cursor to mid-screen and restarts framing.
// Output channel (out_valid/out_stall) carries one result per completed
// packet: cursor position, deltas, buttons and overflow flag.
// Throughput: one byte per cycle while in_stall is low; the whole decode,
// add and clamp is a single combinational pass between the input state and
// the result register, which shows it in the cycle after the third byte.
// While a result waits under out_stall, bytes that do not end a packet are
// still taken; only a packet-ending byte is held off with in_stall.
// Reset: screen 1024x768, cursor at its center (512, 384), framing waits
// for a status byte, no result pending.
// Configuration: APB write of screen_width at 0x0, screen_height at 0x4;
// a new size applies from the next packet or recenter.
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_cursor_tracker_macros.svh"

module ps2_mouse_packet_cursor_tracker #(
    parameter int CURSOR_MARGIN = pmct_pkg::DEFAULT_MARGIN,
    parameter int COORD_BITS    = pmct_pkg::DEFAULT_COORD_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // byte input
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        rx_byte,
    input  logic                              from_mouse,
    input  logic                              recenter,
    // packet result
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [COORD_BITS-1:0]             cursor_x,
    output logic [COORD_BITS-1:0]             cursor_y,
    output logic signed [pmct_pkg::DELTA_W-1:0] delta_x,
    output logic signed [pmct_pkg::DELTA_W-1:0] delta_y,
    output logic                              left_button,
    output logic                              right_button,
    output logic                              middle_button,
    output logic                              overflow_seen,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pmct_pkg::ADDR_W-1:0]       paddr,
    input  logic [pmct_pkg::DATA_W-1:0]       pwdata,
    output logic [pmct_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    localparam int SW = pmct_pkg::SIZE_W;

    // cursor reset positions: center of the reset screen, clamped
    localparam int RST_LIM_X = pmct_pkg::axis_lim_const(int'(pmct_pkg::RST_WIDTH),
                                                        CURSOR_MARGIN, COORD_BITS);
    localparam int RST_LIM_Y = pmct_pkg::axis_lim_const(int'(pmct_pkg::RST_HEIGHT),
                                                        CURSOR_MARGIN, COORD_BITS);
    localparam int RST_HALF_X = int'(pmct_pkg::RST_WIDTH) / 2;
    localparam int RST_HALF_Y = int'(pmct_pkg::RST_HEIGHT) / 2;
    localparam logic [COORD_BITS-1:0] RST_POS_X =
        COORD_BITS'((RST_HALF_X > RST_LIM_X) ? RST_LIM_X : RST_HALF_X);
    localparam logic [COORD_BITS-1:0] RST_POS_Y =
        COORD_BITS'((RST_HALF_Y > RST_LIM_Y) ? RST_LIM_Y : RST_HALF_Y);

    // state
    logic [SW-1:0]          width_reg,  width_next;
    logic [SW-1:0]          height_reg, height_next;
    logic [1:0]             phase_reg,  phase_next;
    logic [7:0]             status_reg, status_next;
    logic [7:0]             xbyte_reg,  xbyte_next;
    logic [COORD_BITS-1:0]  pos_x_reg,  pos_x_next;
    logic [COORD_BITS-1:0]  pos_y_reg,  pos_y_next;
    logic                   out_valid_reg, out_valid_next;

    // result payload
    logic [COORD_BITS-1:0]  cursor_x_reg, cursor_y_reg;
    pmct_pkg::delta_t       delta_x_reg, delta_y_reg;
    logic                   left_reg, right_reg, middle_reg, ovf_reg;

    // datapath
    logic                   in_fire;
    logic                   byte_use;
    logic                   res_item;
    logic                   res_load;
    logic                   cfg_write;
    logic                   ovf;
    logic                   x_neg, y_neg;
    pmct_pkg::delta_t       dx, dy;
    logic signed [pmct_pkg::DELTA_W:0] step_x, step_y;
    logic [COORD_BITS-1:0]  axis_x, axis_y;

    // handshake: only a packet-ending byte waits on a held result
    assign res_item = from_mouse && !recenter && (phase_reg == pmct_pkg::PH_Y);
    assign in_stall = out_valid_reg && out_stall && res_item;
    assign in_fire  = in_valid && !in_stall;
    assign byte_use = in_fire && from_mouse && !recenter;
    assign res_load = in_fire && res_item;

    // delta decode; a zero byte is never sign extended
    assign ovf   = status_reg[pmct_pkg::ST_XOVF] || status_reg[pmct_pkg::ST_YOVF];
    assign x_neg = status_reg[pmct_pkg::ST_XSIGN] && (xbyte_reg != 8'd0);
    assign y_neg = status_reg[pmct_pkg::ST_YSIGN] && (rx_byte != 8'd0);
    assign dx    = ovf ? '0 : pmct_pkg::delta_t'({x_neg, xbyte_reg});
    assign dy    = ovf ? '0 : pmct_pkg::delta_t'({y_neg, rx_byte});
    assign step_x = {dx[pmct_pkg::DELTA_W-1], dx};
    assign step_y = -{dy[pmct_pkg::DELTA_W-1], dy};

    pmct_axis #(
        .CURSOR_MARGIN (CURSOR_MARGIN),
        .COORD_BITS    (COORD_BITS)
    ) u_axis_x (
        .size     (width_reg),
        .pos      (pos_x_reg),
        .step     (step_x),
        .center   (recenter),
        .pos_next (axis_x)
    );

    pmct_axis #(
        .CURSOR_MARGIN (CURSOR_MARGIN),
        .COORD_BITS    (COORD_BITS)
    ) u_axis_y (
        .size     (height_reg),
        .pos      (pos_y_reg),
        .step     (step_y),
        .center   (recenter),
        .pos_next (axis_y)
    );

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                pmct_pkg::REG_WIDTH:  width_next  = pwdata[SW-1:0];
                pmct_pkg::REG_HEIGHT: height_next = pwdata[SW-1:0];
                default:              width_next  = width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            pmct_pkg::REG_WIDTH:  prdata = pmct_pkg::DATA_W'(width_reg);
            pmct_pkg::REG_HEIGHT: prdata = pmct_pkg::DATA_W'(height_reg);
            default:              prdata = '0;
        endcase
    end

    // packet framing
    always_comb
    begin
        phase_next  = phase_reg;
        status_next = status_reg;
        xbyte_next  = xbyte_reg;
        if (in_fire && recenter)
            phase_next = pmct_pkg::PH_STATUS;
        else if (byte_use)
        begin
            case (phase_reg)
                pmct_pkg::PH_X:
                begin
                    xbyte_next = rx_byte;
                    phase_next = pmct_pkg::PH_Y;
                end
                pmct_pkg::PH_Y:
                    phase_next = pmct_pkg::PH_STATUS;
                default:
                begin
                    status_next = rx_byte;
                    phase_next  = rx_byte[pmct_pkg::ST_ONE] ? pmct_pkg::PH_X
                                                            : pmct_pkg::PH_STATUS;
                end
            endcase
        end
    end

    // cursor moves on packet end or recenter
    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        if ((in_fire && recenter) || res_load)
        begin
            pos_x_next = axis_x;
            pos_y_next = axis_y;
        end
    end

    // result register valid
    always_comb
    begin
        if (res_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= pmct_pkg::RST_WIDTH;
            height_reg    <= pmct_pkg::RST_HEIGHT;
            phase_reg     <= pmct_pkg::PH_STATUS;
            status_reg    <= '0;
            xbyte_reg     <= '0;
            pos_x_reg     <= RST_POS_X;
            pos_y_reg     <= RST_POS_Y;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            phase_reg     <= phase_next;
            status_reg    <= status_next;
            xbyte_reg     <= xbyte_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded only when a packet completes
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            cursor_x_reg <= axis_x;
            cursor_y_reg <= axis_y;
            delta_x_reg  <= dx;
            delta_y_reg  <= dy;
            left_reg     <= status_reg[pmct_pkg::ST_LEFT];
            right_reg    <= status_reg[pmct_pkg::ST_RIGHT];
            middle_reg   <= status_reg[pmct_pkg::ST_MIDDLE];
            ovf_reg      <= ovf;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cursor_x      = cursor_x_reg;
    assign cursor_y      = cursor_y_reg;
    assign delta_x       = delta_x_reg;
    assign delta_y       = delta_y_reg;
    assign left_button   = left_reg;
    assign right_button  = right_reg;
    assign middle_button = middle_reg;
    assign overflow_seen = ovf_reg;

    // checks
    `PMCT_NEVER(a_no_overwrite, res_load && out_valid_reg && out_stall, "held result overwritten")
    `PMCT_ASSERT(a_res_ends_packet, res_load |=> phase_reg == pmct_pkg::PH_STATUS, "framing not restarted after packet")
    `PMCT_ASSERT(a_recenter_frame, (in_fire && recenter) |=> (phase_reg == pmct_pkg::PH_STATUS) && !$rose(out_valid_reg), "recenter did not restart framing")
    `PMCT_ASSERT(a_ovf_zero, (out_valid_reg && ovf_reg) |-> (delta_x_reg == 0) && (delta_y_reg == 0), "nonzero delta on overflow")

endmodule
